@@ design/sbl_pkg.sv @@
package sbl_pkg;

  // Request codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Command broadcast from the control logic to every cell.
  typedef struct packed {
    logic       ins_en;
    logic       del_en;
    logic [7:0] value;
  } cell_cmd_t;

  // What a cell hands to its right-hand neighbor; the entry also goes to the left-hand one.
  typedef struct packed {
    logic       lt;
    logic [7:0] entry;
  } cell_link_t;

endpackage

@@ design/sbl_if.sv @@
// Request channel: one insert or delete per transfer.
interface sbl_req_if import sbl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

// Response channel: one status and count per transfer.
interface sbl_rsp_if import sbl_pkg::*; ();
  logic       valid;
  logic       ready;
  status_t    status;
  logic [4:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

@@ design/sorted_byte_list_core.sv @@
// Sorted byte list: keeps up to CAPACITY unsigned bytes in ascending order,
// duplicates allowed, in a row of cells that each hold one entry.
//
// The req channel carries an opcode (insert or delete) and a byte. An insert
// goes in front of any equal entries; a delete removes the first equal entry.
// Every request gives exactly one transfer on the rsp channel with a status
// (inserted, deleted, not found, full, empty) and the count afterwards.
//
// All cells compare against the broadcast value and shift toward their
// neighbor in the same clock edge, so a new request is taken every cycle
// unless a pending response is stalled. The response is in the output
// register in the cycle after the request transfer.
//
// Reset empties the list; stored bytes are not cleared. While the receiver
// stalls a pending response, a new request is taken only when the output
// register is free or being emptied in the same cycle.
module sorted_byte_list_core
  import sbl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic      clk,
  input logic      rst,
  sbl_req_if.sink  req,
  sbl_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW+4:0]       count_ext;
  logic                accept;
  logic                full;
  logic                empty;
  logic                found;
  status_t             status_next;
  cell_cmd_t           cmd;
  cell_link_t          links [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] occupied;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign found     = |match_vec;

  // Broadcast the command to the cells.
  assign cmd.value  = req.item_value;
  assign cmd.ins_en = accept && (req.opcode == OP_INSERT) && !full;
  assign cmd.del_en = accept && (req.opcode == OP_DELETE) && found;

  // Row of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left;
    logic [7:0] right_entry;

    assign occupied[i] = (CW'(i) < count);

    if (i == 0) begin : g_first
      assign left = '{lt: 1'b1, entry: 8'd0};
    end else begin : g_mid
      assign left = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = links[i].entry;
    end else begin : g_inner
      assign right_entry = links[i+1].entry;
    end

    sbl_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occupied[i]),
      .left        (left),
      .right_entry (right_entry),
      .link        (links[i]),
      .match       (match_vec[i])
    );
  end

  // Status and new count for the request.
  always_comb begin
    count_next  = count;
    status_next = ST_INSERTED;
    if (req.opcode == OP_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        count_next  = count + CW'(1);
      end
    end else if (empty) begin
      status_next = ST_EMPTY;
    end else if (!found) begin
      status_next = ST_NOT_FOUND;
    end else begin
      status_next = ST_DELETED;
      count_next  = count - CW'(1);
    end
  end

  // Count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  assign count_ext = {5'd0, count_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status_next;
      rsp.entry_count <= count_ext[4:0];
    end
  end

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_en |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.del_en |=> count == $past(count) - CW'(1))
    else $error("delete did not shrink the count");

  a_no_match_when_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !found)
    else $error("match reported in an empty list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && (req.opcode == OP_INSERT) && full |=> rsp.status == ST_FULL)
    else $error("insert into full list not reported as full");

endmodule

@@ design/sbl_cell.sv @@
module sbl_cell
  import sbl_pkg::*;
(
  input  logic       clk,
  input  cell_cmd_t  cmd,
  input  logic       occupied,
  input  cell_link_t left,
  input  logic [7:0] right_entry,
  output cell_link_t link,
  output logic       match
);

  logic [7:0] entry;
  logic       lt;
  logic       ge;

  // Compare the stored byte against the broadcast value.
  assign lt    = occupied && (entry < cmd.value);
  assign ge    = occupied && (entry >= cmd.value);
  assign match = occupied && (entry == cmd.value);

  assign link.lt    = lt;
  assign link.entry = entry;

  // An insert shifts entries at or above the value one place right and drops
  // the value into the first such cell; a delete pulls from the right every
  // entry at or above the first match.
  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      if (!lt) begin
        entry <= left.lt ? cmd.value : left.entry;
      end
    end else if (cmd.del_en && ge) begin
      entry <= right_entry;
    end
  end

endmodule

@@ sim/sorted_byte_list_core_tb.sv @@
module sorted_byte_list_core_tb;
  import sbl_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int CYCLE_LIMIT = 200000;

  // One expected response: status and entry count after the request.
  typedef struct {
    status_t    status;
    logic [4:0] entry_count;
  } list_result_t;

  logic clk;
  logic rst;

  sbl_req_if req_if ();
  sbl_rsp_if rsp_if ();

  sorted_byte_list_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  // Shadow copy of the list contents, kept in ascending order.
  logic [7:0]   shadow_list[$];
  list_result_t pending_results[$];

  int error_count;
  int cycle_count;
  int burst_left;
  int max_gap;
  int hold_request;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one request to the shadow list and return the response it must give.
  function automatic list_result_t apply_request(logic op, logic [7:0] val);
    list_result_t res;
    int pos;
    pos = 0;
    if (op == OP_INSERT) begin
      if (shadow_list.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        while (pos < shadow_list.size() && shadow_list[pos] < val) pos++;
        shadow_list.insert(pos, val);
        res.status = ST_INSERTED;
      end
    end else begin
      if (shadow_list.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        while (pos < shadow_list.size() && shadow_list[pos] != val) pos++;
        if (pos >= shadow_list.size()) begin
          res.status = ST_NOT_FOUND;
        end else begin
          shadow_list.delete(pos);
          res.status = ST_DELETED;
        end
      end
    end
    res.entry_count = 5'(shadow_list.size());
    return res;
  endfunction

  // Offer one request, in bursts with random gaps, and wait for its transfer.
  task automatic send_request(input logic op, input logic [7:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.item_value <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(apply_request(op, val));
    burst_left--;
  endtask

  // Requests on an empty list, and deletes of zero and of a missing value.
  task automatic test_empty_list();
    send_request(OP_DELETE, 8'd0);
    send_request(OP_DELETE, 8'd255);
    send_request(OP_INSERT, 8'd0);
    send_request(OP_DELETE, 8'd0);
    send_request(OP_INSERT, 8'd255);
    send_request(OP_DELETE, 8'd128);
  endtask

  // Fill the list with extremes and duplicates, insert into the full list, then delete a duplicate.
  task automatic test_fill_to_capacity();
    logic [7:0] fill_values[16];
    fill_values = '{8'd128, 8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd7, 8'd128,
                    8'd64, 8'd200, 8'd3, 8'd3, 8'd250, 8'd100, 8'd0, 8'd255};
    foreach (fill_values[i]) begin
      if (shadow_list.size() < CAPACITY) send_request(OP_INSERT, fill_values[i]);
    end
    send_request(OP_INSERT, 8'd77);
    send_request(OP_INSERT, 8'd0);
    send_request(OP_DELETE, 8'd128);
  endtask

  // Random requests; deletes mostly name a value that is stored.
  task automatic test_random_mix(input int n_items, input int insert_pct,
                                 input bit narrow);
    logic       op;
    logic [7:0] val;
    int         pick;
    repeat (n_items) begin
      op   = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
      pick = $urandom_range(0, 9);
      if (op == OP_DELETE && shadow_list.size() != 0 && pick < 7) begin
        val = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
      end else if (pick == 9) begin
        val = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
      end else if (narrow) begin
        val = 8'($urandom_range(0, 7));
      end else begin
        val = 8'($urandom_range(0, 255));
      end
      send_request(op, val);
    end
  endtask

  // Hold the response side off while requests keep coming back to back.
  task automatic test_output_stall();
    int saved_gap;
    saved_gap    = max_gap;
    max_gap      = 0;
    hold_request = 120;
    test_random_mix(40, 50, 1'b1);
    max_gap = saved_gap;
  endtask

  // Stop offering requests and wait until every response has arrived.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Response ready: a long hold-off on request, otherwise a random duty cycle
  // that changes from phase to phase.
  initial begin
    int hold_left;
    int stall_pct;
    int phase_left;
    hold_left  = 0;
    stall_pct  = 0;
    phase_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (phase_left == 0) begin
        phase_left = 50;
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Compare each response transfer with the oldest expectation.
  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $error("response transfer with none expected");
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_if.status !== exp_res.status) begin
          error_count++;
          $error("status: expected %0d, actual %0d", exp_res.status, rsp_if.status);
        end
        if (rsp_if.entry_count !== exp_res.entry_count) begin
          error_count++;
          $error("entry_count: expected %0d, actual %0d",
                 exp_res.entry_count, rsp_if.entry_count);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sorted_byte_list_core] ERROR");
      $finish;
    end
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin
    error_count  = 0;
    cycle_count  = 0;
    burst_left   = 0;
    max_gap      = 6;
    hold_request = 0;
    rst               <= 1'b1;
    req_if.valid      <= 1'b0;
    req_if.opcode     <= OP_INSERT;
    req_if.item_value <= 8'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    shadow_list.delete();

    test_empty_list();
    test_fill_to_capacity();
    test_random_mix(300, 70, 1'b0);
    test_output_stall();
    test_random_mix(300, 30, 1'b1);
    max_gap = 2;
    test_random_mix(300, 50, 1'b1);
    max_gap = 8;
    test_random_mix(250, 55, 1'b0);
    drain_responses();

    if (error_count == 0) begin
      $display("[sorted_byte_list_core] OK");
    end else begin
      $display("[sorted_byte_list_core] ERROR");
    end
    $finish;
  end

endmodule
